### rtl/att_pkg.sv
`default_nettype none

package att_pkg;

  localparam int TRACK_ENTRIES_DEF = 64;

  localparam int ADDR_W = 48;
  localparam int SIZE_W = 32;
  localparam int SUM_W  = 48;
  localparam int CNT_W  = 32;
  localparam int LIVE_W = 7;

  localparam logic [1:0] OP_RECORD  = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_RECOUNT = 2'd2;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_PARAM = 2'd1;
  localparam logic [1:0] STS_ERROR = 2'd2;
  localparam logic [1:0] STS_FULL  = 2'd3;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] size;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SUM_W-1:0]  alloc_bytes;
    logic [SUM_W-1:0]  freed_bytes;
    logic [SUM_W-1:0]  live_bytes;
    logic [SUM_W-1:0]  peak_bytes;
    logic [CNT_W-1:0]  rec_count;
    logic [CNT_W-1:0]  rel_count;
    logic [LIVE_W-1:0] active_count;
    logic [LIVE_W-1:0] leak_tally;
  } out_item_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_start;
    logic clear_step;
    logic decode;
    logic scan_start;
    logic scan_step;
    logic resolve;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_req;
    logic need_scan;
    logic idx_last;
    logic hit;
    logic miss;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

### rtl/att_ctrl.sv
`default_nettype none

module att_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire att_pkg::sts_t sts,
  output att_pkg::cmd_t      cmd
);

  att_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= att_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      att_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.idx_last) begin
          state_nxt = att_pkg::ST_IDLE;
        end
      end
      att_pkg::ST_IDLE: begin
        in_ready = !sts.clr_req;
        if (in_valid && !sts.clr_req) begin
          state_nxt = att_pkg::ST_DECODE;
        end
      end
      att_pkg::ST_DECODE: begin
        cmd.decode = 1'b1;
        if (sts.need_scan) begin
          cmd.scan_start = 1'b1;
          state_nxt      = att_pkg::ST_SCAN;
        end else begin
          state_nxt = att_pkg::ST_DONE;
        end
      end
      att_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.hit || sts.miss) begin
          cmd.resolve = 1'b1;
          state_nxt   = att_pkg::ST_DONE;
        end
      end
      att_pkg::ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = att_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = att_pkg::ST_IDLE;
      end
    endcase
    // enable rising: restart the table wipe from entry 0
    if (sts.clr_req) begin
      cmd             = '0;
      cmd.clear_start = 1'b1;
      state_nxt       = att_pkg::ST_CLEAR;
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in flight");

  a_clr_enters_wipe: assert property (@(posedge clk) disable iff (!rst_n)
    sts.clr_req |=> (state_r == att_pkg::ST_CLEAR))
    else $error("enable rise did not start table wipe");

endmodule

`default_nettype wire

### rtl/att_dp.sv
`default_nettype none

module att_dp #(
  parameter int TRACK_ENTRIES = att_pkg::TRACK_ENTRIES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire att_pkg::in_item_t in_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output att_pkg::out_item_t     out_data,
  input  wire att_pkg::cmd_t     cmd,
  output att_pkg::sts_t          sts
);

  localparam int IDX_W = (TRACK_ENTRIES > 1) ? $clog2(TRACK_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TRACK_ENTRIES - 1);
  localparam int SW = att_pkg::SUM_W;
  localparam int CW = att_pkg::CNT_W;
  localparam int LW = att_pkg::LIVE_W;

  att_pkg::entry_t    mem_r [TRACK_ENTRIES];
  att_pkg::entry_t    rd_q_r;
  att_pkg::in_item_t  item_r;
  att_pkg::out_item_t out_r;
  logic [1:0]         status_r;

  logic              en_r;
  logic [IDX_W-1:0]  idx_r, chk_idx_r;
  logic              chk_vld_r, chk_last_r;
  logic              out_valid_r;
  logic [SW-1:0]     sum_alloc_r, sum_freed_r, use_r, peak_r;
  logic [CW-1:0]     rec_cnt_r, rel_cnt_r;
  logic [LW-1:0]     live_r, leaks_r;

  logic              rec, match, need_scan;
  logic [1:0]        imm_sts;
  logic [SW-1:0]     size_ext, use_up, use_dn;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  att_pkg::entry_t   mem_wd;

  assign cfg_ready = 1'b1;

  assign rec   = (item_r.opcode == att_pkg::OP_RECORD);
  assign match = rec ? !rd_q_r.valid
                     : (rd_q_r.valid && (rd_q_r.address == item_r.address));

  // record adds the new size, release takes back the stored one
  assign size_ext = SW'(rec ? item_r.size : rd_q_r.size);
  assign use_up   = use_r + size_ext;
  assign use_dn   = use_r - size_ext;

  always_comb begin
    need_scan = 1'b0;
    imm_sts   = att_pkg::STS_OK;
    if (item_r.opcode == att_pkg::OP_RECOUNT) begin
      imm_sts = att_pkg::STS_OK;
    end else if (!(item_r.opcode inside {att_pkg::OP_RECORD, att_pkg::OP_RELEASE})) begin
      imm_sts = att_pkg::STS_ERROR;
    end else if (item_r.address == '0) begin
      imm_sts = att_pkg::STS_PARAM;
    end else if (!en_r) begin
      imm_sts = att_pkg::STS_ERROR;
    end else begin
      need_scan = 1'b1;
    end
  end

  always_comb begin
    sts.clr_req   = cfg_valid && cfg_data && !en_r;
    sts.need_scan = need_scan;
    sts.idx_last  = (idx_r == IDX_LAST);
    sts.hit       = chk_vld_r && match;
    sts.miss      = chk_vld_r && chk_last_r && !match;
    sts.out_busy  = out_valid_r && !out_ready;
  end

  // table write port: wipe pass or the hit entry
  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_r;
    mem_wd = '0;
    if (cmd.clear_step) begin
      mem_we = 1'b1;
    end else if (cmd.resolve && sts.hit) begin
      mem_we = 1'b1;
      mem_wa = chk_idx_r;
      if (rec) begin
        mem_wd = {1'b1, item_r.address, item_r.size};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_wa] <= mem_wd;
    end
    if (cmd.scan_step) begin
      rd_q_r <= mem_r[idx_r];
    end
  end

  // walk pointer and compare stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      chk_idx_r  <= '0;
      chk_vld_r  <= 1'b0;
      chk_last_r <= 1'b0;
    end else if (cmd.clear_start || cmd.scan_start) begin
      idx_r     <= '0;
      chk_vld_r <= 1'b0;
    end else if (cmd.clear_step || cmd.scan_step) begin
      if (idx_r != IDX_LAST) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (cmd.scan_step) begin
        chk_vld_r  <= 1'b1;
        chk_idx_r  <= idx_r;
        chk_last_r <= (idx_r == IDX_LAST);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= 1'b0;
      sum_alloc_r <= '0;
      sum_freed_r <= '0;
      use_r       <= '0;
      peak_r      <= '0;
      rec_cnt_r   <= '0;
      rel_cnt_r   <= '0;
      live_r      <= '0;
      leaks_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        en_r <= cfg_data;
      end
      if (sts.clr_req) begin
        sum_alloc_r <= '0;
        sum_freed_r <= '0;
        use_r       <= '0;
        peak_r      <= '0;
        rec_cnt_r   <= '0;
        rel_cnt_r   <= '0;
        live_r      <= '0;
        leaks_r     <= '0;
      end else if (cmd.decode && !need_scan) begin
        if (item_r.opcode == att_pkg::OP_RECOUNT) begin
          leaks_r <= live_r;
        end
      end else if (cmd.resolve && sts.hit) begin
        if (rec) begin
          sum_alloc_r <= sum_alloc_r + size_ext;
          use_r       <= use_up;
          if (use_up > peak_r) begin
            peak_r <= use_up;
          end
          rec_cnt_r <= rec_cnt_r + CW'(1);
          live_r    <= live_r + LW'(1);
        end else begin
          sum_freed_r <= sum_freed_r + size_ext;
          use_r       <= use_dn;
          rel_cnt_r   <= rel_cnt_r + CW'(1);
          live_r      <= live_r - LW'(1);
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (cmd.decode && !need_scan) begin
      status_r <= imm_sts;
    end else if (cmd.resolve) begin
      if (sts.hit) begin
        status_r <= att_pkg::STS_OK;
      end else begin
        status_r <= rec ? att_pkg::STS_FULL : att_pkg::STS_ERROR;
      end
    end
    if (cmd.out_load) begin
      out_r.status       <= status_r;
      out_r.alloc_bytes  <= sum_alloc_r;
      out_r.freed_bytes  <= sum_freed_r;
      out_r.live_bytes   <= use_r;
      out_r.peak_bytes   <= peak_r;
      out_r.rec_count    <= rec_cnt_r;
      out_r.rel_count    <= rel_cnt_r;
      out_r.active_count <= live_r;
      out_r.leak_tally   <= leaks_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_clr_stats: assert property (@(posedge clk) disable iff (!rst_n)
    sts.clr_req |=> (sum_alloc_r == '0 && sum_freed_r == '0 && use_r == '0 &&
                     peak_r == '0 && live_r == '0))
    else $error("statistics not cleared on enable rise");

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (TRACK_ENTRIES >= 128) || (int'(live_r) <= TRACK_ENTRIES))
    else $error("live entry count above table depth");

  a_rec_live: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.resolve && sts.hit && rec && !sts.clr_req) |=>
      (live_r == $past(live_r) + LW'(1)))
    else $error("record hit did not bump live count");

endmodule

`default_nettype wire

### rtl/allocation_tracking_table.sv
// Allocation tracking table: one result per input item.
// Input channel in_valid/in_ready/in_data carries opcode, address and size;
// result channel out_valid/out_ready/out_data carries status plus a snapshot
// of all statistics after the item is applied. cfg_valid/cfg_data write the
// enable bit; cfg_ready is always high.
// Recount, bad opcode, zero address or disabled are answered with no table walk;
// record/release walks the table from entry 0 and stops at the first free entry
// (record) or matching entry (release), else reports table full or release not
// found after the last entry. The walk reads one table entry per cycle through
// the single read port of the table RAM. in_ready returns the cycle after the
// result is loaded, so only one item is in flight at a time.
// A finished result sits in the output register; a new item is taken while it
// waits. When the receiver stalls with a result already waiting, the next
// item holds in its final state until the register frees up.
// After reset, and whenever enable goes from 0 to 1, the statistics clear at
// once and a wipe pass clears the table entry by entry; in_ready is low during
// the pass.
`default_nettype none

module allocation_tracking_table #(
  parameter int TRACK_ENTRIES = att_pkg::TRACK_ENTRIES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire att_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output att_pkg::out_item_t     out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_data
);

  att_pkg::cmd_t cmd;  // controller commands
  att_pkg::sts_t sts;  // datapath status back to controller

  att_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table RAM, walk pointer, statistics and output register
  att_dp #(
    .TRACK_ENTRIES (TRACK_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import att_pkg::*;

  localparam int NSLOTS      = TRACK_ENTRIES_DEF;
  localparam int POOL_SIZE   = 24;     // small pool so duplicates and release hits are common
  localparam int HOLD_CYCLES = 300;    // long receiver hold-off
  localparam int STALL_LIMIT = 4000;   // cycles without any transfer before giving up
  localparam int TAIL_CYCLES = NSLOTS + 8;

  // opcode 3 has no package name; the block answers it with an error
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // ---------------------------------------------------------------------------
  // Ledger: mirrors the allocation table and its statistics, turns each
  // accepted request into the snapshot the block must return, and checks
  // returned snapshots in order.
  // ---------------------------------------------------------------------------
  class usage_ledger;
    bit              tracking_on;
    bit              slot_live [NSLOTS];
    bit [ADDR_W-1:0] slot_addr [NSLOTS];
    bit [SIZE_W-1:0] slot_size [NSLOTS];
    bit [SUM_W-1:0]  alloc_sum;
    bit [SUM_W-1:0]  freed_sum;
    bit [SUM_W-1:0]  in_use;
    bit [SUM_W-1:0]  peak;
    bit [CNT_W-1:0]  records;
    bit [CNT_W-1:0]  releases;
    bit [LIVE_W-1:0] live;
    bit [LIVE_W-1:0] leaks;
    out_item_t       pending_snapshots[$];
    int              requests;
    int              snapshots;
    int              mismatches;
    int              status_seen[4];
    int              most_live;

    function new();
      tracking_on = 1'b0;
      wipe();
    endfunction

    function void wipe();
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      alloc_sum = '0;
      freed_sum = '0;
      in_use    = '0;
      peak      = '0;
      records   = '0;
      releases  = '0;
      live      = '0;
      leaks     = '0;
    endfunction

    // only a 0 -> 1 transition clears
    function void apply_enable(bit on);
      if (on && !tracking_on) wipe();
      tracking_on = on;
    endfunction

    function int outstanding();
      return pending_snapshots.size();
    endfunction

    function void log_request(in_item_t req);
      out_item_t  snap;
      logic [1:0] st;
      int         hit;
      int         n;
      int         i;
      requests++;
      hit = -1;
      n = 0;
      case (req.opcode)
        OP_RECOUNT: begin
          // address and size ignored, works while disabled
          for (i = 0; i < NSLOTS; i++)
            if (slot_live[i]) n++;
          leaks = n[LIVE_W-1:0];
          st = STS_OK;
        end
        OP_RECORD, OP_RELEASE: begin
          if (req.address == '0) begin
            st = STS_PARAM;
          end else if (!tracking_on) begin
            st = STS_ERROR;
          end else if (req.opcode == OP_RECORD) begin
            for (i = NSLOTS - 1; i >= 0; i--)
              if (!slot_live[i]) hit = i;
            if (hit < 0) begin
              st = STS_FULL;
            end else begin
              slot_live[hit] = 1'b1;
              slot_addr[hit] = req.address;
              slot_size[hit] = req.size;
              alloc_sum = alloc_sum + req.size;
              in_use    = in_use + req.size;
              records   = records + 1'b1;
              live      = live + 1'b1;
              if (in_use > peak) peak = in_use;
              st = STS_OK;
            end
          end else begin
            // lowest live entry with a matching address
            for (i = NSLOTS - 1; i >= 0; i--)
              if (slot_live[i] && slot_addr[i] == req.address) hit = i;
            if (hit < 0) begin
              st = STS_ERROR;
            end else begin
              freed_sum = freed_sum + slot_size[hit];
              in_use    = in_use - slot_size[hit];
              releases  = releases + 1'b1;
              live      = live - 1'b1;
              slot_live[hit] = 1'b0;
              st = STS_OK;
            end
          end
        end
        default: begin
          st = STS_ERROR;
        end
      endcase
      if (live > most_live) most_live = live;
      snap.status       = st;
      snap.alloc_bytes  = alloc_sum;
      snap.freed_bytes  = freed_sum;
      snap.live_bytes   = in_use;
      snap.peak_bytes   = peak;
      snap.rec_count    = records;
      snap.rel_count    = releases;
      snap.active_count = live;
      snap.leak_tally   = leaks;
      pending_snapshots.push_back(snap);
    endfunction

    function void show_field(string name, logic [SUM_W-1:0] exp_v, logic [SUM_W-1:0] act_v);
      if (exp_v !== act_v)
        $display("    %s expected %h got %h", name, exp_v, act_v);
    endfunction

    function void match_snapshot(out_item_t got);
      out_item_t want;
      snapshots++;
      if (pending_snapshots.size() == 0) begin
        if (mismatches < 10)
          $display("ERROR %0t: result %0d arrived with nothing expected", $time, snapshots);
        mismatches++;
        return;
      end
      want = pending_snapshots.pop_front();
      status_seen[want.status]++;
      if (got !== want) begin
        if (mismatches < 10) begin
          $display("ERROR %0t: result %0d differs", $time, snapshots);
          show_field("status", SUM_W'(want.status), SUM_W'(got.status));
          show_field("alloc_bytes", want.alloc_bytes, got.alloc_bytes);
          show_field("freed_bytes", want.freed_bytes, got.freed_bytes);
          show_field("live_bytes", want.live_bytes, got.live_bytes);
          show_field("peak_bytes", want.peak_bytes, got.peak_bytes);
          show_field("rec_count", SUM_W'(want.rec_count), SUM_W'(got.rec_count));
          show_field("rel_count", SUM_W'(want.rel_count), SUM_W'(got.rel_count));
          show_field("active_count", SUM_W'(want.active_count), SUM_W'(got.active_count));
          show_field("leak_tally", SUM_W'(want.leak_tally), SUM_W'(got.leak_tally));
        end
        mismatches++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data  = 1'b0;

  allocation_tracking_table uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  usage_ledger     ledger = new();
  bit [ADDR_W-1:0] addr_pool [POOL_SIZE];

  // traffic knobs, changed per phase by the main sequence
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // long hold-off: main sequence bumps hold_asks, receiver serves it
  int hold_asks = 0;
  int hold_done = 0;
  int hold_cnt  = 0;

  int quiet_cycles   = 0;
  int directed_items = 0;
  int enable_writes  = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Monitors: sample at the edge, before any NBA from this edge lands
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready === 1'b1)
      ledger.log_request(in_data);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready)
      ledger.match_snapshot(out_data);
  end

  // enable changes take effect in the mirror at the same transfer as in the block
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready === 1'b1) begin
      ledger.apply_enable(cfg_data);
      enable_writes++;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, or a counted hold-off when one is asked for
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (hold_asks != hold_done) begin
      hold_done <= hold_done + 1;
      hold_cnt  <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any transfer on any channel resets the count
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("ERROR %0t: no transfer for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, ledger.outstanding());
      $display("FAIL allocation_tracking_table");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  function automatic in_item_t request_of(logic [1:0] op, logic [ADDR_W-1:0] a,
                                          logic [SIZE_W-1:0] s);
    in_item_t r;
    r.opcode  = op;
    r.address = a;
    r.size    = s;
    return r;
  endfunction

  // valid stays up across back-to-back transfers; it only drops on an idle cycle
  task automatic send_item(input in_item_t req);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
  endtask

  // stop offering and wait until every snapshot is back and the block is idle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.outstanding() != 0 || in_ready !== 1'b1) @(posedge clk);
  endtask

  task automatic program_enable(input logic on);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= on;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_directed(input logic [1:0] op, input logic [ADDR_W-1:0] a,
                               input logic [SIZE_W-1:0] s);
    send_item(request_of(op, a, s));
    directed_items++;
  endtask

  // Mostly well-formed traffic over a small address pool; releases usually aim
  // at an address that is live in the mirror so they actually free something.
  function automatic in_item_t make_request(int rec_pct, int rel_pct);
    in_item_t r;
    int       roll;
    int       start;
    int       k;
    bit       found;
    roll      = $urandom_range(99);
    r.address = addr_pool[$urandom_range(POOL_SIZE - 1)];
    case ($urandom_range(4))
      0:       r.size = $urandom_range(255);
      1, 2:    r.size = $urandom;
      3:       r.size = $urandom_range(1) ? '1 : '0;
      default: r.size = $urandom_range(65535);
    endcase
    if (roll < rec_pct)                r.opcode = OP_RECORD;
    else if (roll < rec_pct + rel_pct) r.opcode = OP_RELEASE;
    else if (roll < 96)                r.opcode = OP_RECOUNT;
    else                               r.opcode = OP_UNUSED;

    if (r.opcode == OP_RELEASE && $urandom_range(3) != 0) begin
      found = 1'b0;
      start = $urandom_range(NSLOTS - 1);
      for (k = 0; k < NSLOTS; k++) begin
        if (!found && ledger.slot_live[(start + k) % NSLOTS]) begin
          r.address = ledger.slot_addr[(start + k) % NSLOTS];
          found = 1'b1;
        end
      end
    end

    // noise: zero address or a stray address that matches nothing
    roll = $urandom_range(99);
    if (roll < 4)       r.address = '0;
    else if (roll < 10) r.address = ADDR_W'({$urandom, $urandom});
    return r;
  endfunction

  task automatic run_phase(int n, int rec_pct, int rel_pct, int idle_pct, int stall);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    repeat (n) send_item(make_request(rec_pct, rel_pct));
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    addr_pool[0] = '1;
    addr_pool[1] = 48'h1;
    for (int i = 2; i < POOL_SIZE; i++) begin
      addr_pool[i] = ADDR_W'({$urandom, $urandom});
      if (addr_pool[i] == '0) addr_pool[i] = 48'h2;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // disabled: only recount and zero-address checks do anything useful
    program_enable(1'b0);
    send_directed(OP_RECORD,  48'h1234, 32'd100);       // disabled error
    send_directed(OP_RELEASE, '0,       32'd9);         // zero address
    send_directed(OP_RECOUNT, 48'h77,   '1);            // recount while disabled
    send_directed(OP_UNUSED,  '0,       '0);            // unused opcode beats zero address

    // enable: wipe pass, then the field extremes and table corner cases
    program_enable(1'b1);
    send_directed(OP_RECORD,  '1,       '1);            // max address, max size
    send_directed(OP_RECORD,  48'h1,    '0);            // zero-byte allocation
    send_directed(OP_RECORD,  48'h1,    32'd5);         // duplicate address
    send_directed(OP_RECORD,  '0,       '1);            // zero address record
    send_directed(OP_RELEASE, 48'h1,    '0);            // frees lowest duplicate
    send_directed(OP_RELEASE, 48'h1,    '0);            // frees the other one
    send_directed(OP_RELEASE, 48'h1,    '0);            // nothing left: not found
    send_directed(OP_RECORD,  48'hAAAA_AAAA_AAAA, 32'h5555_5555);
    send_directed(OP_RECORD,  48'h5555_5555_5555, 32'hAAAA_AAAA);
    send_directed(OP_RECOUNT, '0,       '0);
    send_directed(OP_RELEASE, '1,       32'h1234);      // usage drops, peak holds
    send_directed(OP_RECORD,  48'h9,    32'd7);         // below peak
    send_directed(OP_UNUSED,  48'hABC,  32'd1);
    send_directed(OP_RELEASE, 48'h5555_5555_5555, '0);
    send_directed(OP_RELEASE, '0,       '0);
    send_directed(OP_RECOUNT, '1,       '1);

    // record-heavy back-to-back traffic runs the table into full
    run_phase(150, 85, 10, 0, 0);
    // sparse sender, mostly releases
    run_phase(150, 40, 50, 79, 0);

    // disabled with a live table: contents must survive; write 0 twice
    program_enable(1'b0);
    run_phase(60, 45, 40, 0, 79);
    program_enable(1'b0);
    run_phase(40, 45, 40, 0, 79);

    // re-enable clears everything; long receiver hold-off while the sender
    // keeps offering so the block backs up and drops in_ready
    program_enable(1'b1);
    hold_asks <= hold_asks + 1;
    run_phase(200, 60, 30, 18, 18);

    // enable written again while on: no clear
    program_enable(1'b1);
    run_phase(200, 50, 40, 18, 18);

    // fill again at full rate, then drain the table
    run_phase(100, 85, 5, 0, 0);
    run_phase(100, 20, 70, 0, 0);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (ledger.outstanding() != 0) begin
      $display("ERROR: %0d expected results never arrived", ledger.outstanding());
      ledger.mismatches++;
    end

    $display("Run: %0d requests (%0d directed), %0d results checked, %0d enable writes",
             ledger.requests, directed_items, ledger.snapshots, enable_writes);
    $display("Status mix ok/zero-addr/error/full %0d/%0d/%0d/%0d, most live entries %0d",
             ledger.status_seen[STS_OK], ledger.status_seen[STS_PARAM],
             ledger.status_seen[STS_ERROR], ledger.status_seen[STS_FULL], ledger.most_live);
    if (ledger.mismatches == 0) begin
      $display("PASS allocation_tracking_table");
    end else begin
      $display("%0d mismatching results", ledger.mismatches);
      $display("FAIL allocation_tracking_table");
    end
    $finish;
  end

endmodule
